>>> design/smei_pkg.sv
`timescale 1ns / 1ps

package smei_pkg;

  localparam int unsigned MaxCellsDef   = 1024;
  localparam int unsigned MaxDofDef     = 2;
  localparam int unsigned StencilPoints = 7;

  localparam int unsigned IdxW  = 16;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned DataW = 64;
  localparam int unsigned OutAW = 15;

  // configuration register indexes
  localparam logic [1:0] CFG_CELLS_X = 2'd0;
  localparam logic [1:0] CFG_CELLS_Y = 2'd1;
  localparam logic [1:0] CFG_DOF     = 2'd2;

  // result codes
  localparam logic [1:0] ERR_OK           = 2'd0;
  localparam logic [1:0] ERR_NOT_NEIGHBOR = 2'd1;
  localparam logic [1:0] ERR_OUTSIDE      = 2'd2;

  // stencil points
  localparam logic [2:0] PT_CENTER = 3'd0;
  localparam logic [2:0] PT_XM     = 3'd1;
  localparam logic [2:0] PT_XP     = 3'd2;
  localparam logic [2:0] PT_YM     = 3'd3;
  localparam logic [2:0] PT_YP     = 3'd4;
  localparam logic [2:0] PT_ZM     = 3'd5;
  localparam logic [2:0] PT_ZP     = 3'd6;

  typedef struct packed {
    logic [IdxW-1:0]  row_index;
    logic [IdxW-1:0]  col_index;
    logic             block_row;
    logic             block_col;
    logic [DataW-1:0] value;
    logic             accumulate;
  } in_item_t;

  typedef struct packed {
    logic [OutAW-1:0] entry_address;
    logic [DataW-1:0] new_value;
    logic [1:0]       error_code;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SETUP,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_POINT,
    OP_SUM,
    OP_AMUL,
    OP_ACHK,
    OP_READ,
    OP_INSERT,
    OP_UNPACK,
    OP_ALIGN,
    OP_ADD,
    OP_NORM,
    OP_ROUND,
    OP_WRITE,
    OP_LOAD_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_POINT,
    ST_SUM,
    ST_AMUL,
    ST_ACHK,
    ST_DECIDE,
    ST_INSERT,
    ST_UNPACK,
    ST_ALIGN,
    ST_ADD,
    ST_NORM,
    ST_WRITE,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic clear_done;
    logic div_step_last;
    logic div_phase_last;
    logic err;
    logic accumulate;
    logic fp_special;
    logic norm_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/smei_ram.sv
`timescale 1ns / 1ps

module smei_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/smei_dp.sv
`timescale 1ns / 1ps

module smei_dp
  import smei_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MaxCellsDef,
  parameter int unsigned MAX_DOF   = MaxDofDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_op_e          op_i,
  output dp_status_t      status_o,
  input  in_item_t        in_data_i,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  localparam int unsigned StoreDepth = MAX_CELLS * StencilPoints * MAX_DOF * MAX_DOF;
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  function automatic logic [3:0] stencil_point(input logic signed [16:0] dx,
                                               input logic signed [16:0] dy,
                                               input logic signed [16:0] dz);
    logic [3:0] r;
    r = 4'b0000;
    if (dy == 17'sd0 && dz == 17'sd0 && dx == 17'sd0)  r = {1'b1, PT_CENTER};
    else if (dy == 17'sd0 && dz == 17'sd0 && dx == -17'sd1) r = {1'b1, PT_XM};
    else if (dy == 17'sd0 && dz == 17'sd0 && dx == 17'sd1)  r = {1'b1, PT_XP};
    else if (dx == 17'sd0 && dz == 17'sd0 && dy == -17'sd1) r = {1'b1, PT_YM};
    else if (dx == 17'sd0 && dz == 17'sd0 && dy == 17'sd1)  r = {1'b1, PT_YP};
    else if (dx == 17'sd0 && dy == 17'sd0 && dz == -17'sd1) r = {1'b1, PT_ZM};
    else if (dx == 17'sd0 && dy == 17'sd0 && dz == 17'sd1)  r = {1'b1, PT_ZP};
    return r;
  endfunction

  // configuration
  logic [CfgW-1:0] cells_x_q, cells_y_q;
  logic [1:0]      dof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CfgW'(1);
      cells_y_q <= CfgW'(1);
      dof_q     <= 2'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CELLS_X: cells_x_q <= cfg_data_i;
        CFG_CELLS_Y: cells_y_q <= cfg_data_i;
        CFG_DOF:     dof_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [1:0] dsz;
  logic [3:0] dd;
  logic [6:0] kmul;

  always_comb begin
    if (dof_q == 2'd0) begin
      dsz = 2'd1;
    end else if (32'(dof_q) > MAX_DOF) begin
      dsz = 2'(MAX_DOF);
    end else begin
      dsz = dof_q;
    end
  end

  assign dd   = 4'(dsz) * 4'(dsz);
  assign kmul = 7'(dd) * 7'd7;

  // item and index registers
  logic [IdxW-1:0]  row_q, col_q;
  logic             brow_q, bcol_q, acc_q;
  logic [DataW-1:0] value_q;
  logic [11:0]      gx_q;
  logic [23:0]      plane_q;
  logic [21:0]      nxny_q;

  // divider
  logic [1:0]  phase_q;
  logic [3:0]  cnt_q;
  logic [15:0] dvd_q, rem_q, quo_q, prem_q;
  logic [23:0] divisor_q;
  logic [15:0] zq_r_q, yq_r_q, zq_c_q, yq_c_q;
  logic [11:0] xm_r_q, xm_c_q;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_n, quo_n;

  assign trial = {rem_q, dvd_q[15]};
  assign ge    = {7'b0, trial} >= divisor_q;
  assign rem_n = ge ? 16'({7'b0, trial} - divisor_q) : trial[15:0];
  assign quo_n = {quo_q[14:0], ge};

  // cell and address
  logic signed [16:0] zr, yr, dx, dy, dz;
  logic signed [12:0] xr;
  logic signed [39:0] t1_d, t1_q;
  logic signed [28:0] t2_d, t2_q;
  logic signed [12:0] xr_q;
  logic signed [40:0] cell_q;
  logic [3:0]         ptres;
  logic [2:0]         pt_q;
  logic               nb_err_q, fit_q;
  logic [47:0]        prod_q, addr_d, addr_q;
  logic [7:0]         ofs_q;
  logic [1:0]         err_q, err_d;

  assign zr = $signed({1'b0, zq_r_q}) - 17'sd1;
  assign yr = $signed({1'b0, yq_r_q}) - 17'sd1;
  assign xr = $signed({1'b0, xm_r_q}) - 13'sd1;
  assign dx = $signed({5'b0, xm_c_q}) - $signed({5'b0, xm_r_q});
  assign dy = $signed({1'b0, yq_c_q}) - $signed({1'b0, yq_r_q});
  assign dz = $signed({1'b0, zq_c_q}) - $signed({1'b0, zq_r_q});
  assign ptres = stencil_point(dx, dy, dz);
  assign t1_d  = zr * $signed({1'b0, nxny_q});
  assign t2_d  = yr * $signed({1'b0, cells_x_q});

  assign addr_d = prod_q + 48'(ofs_q);
  always_comb begin
    if (nb_err_q) begin
      err_d = ERR_NOT_NEIGHBOR;
    end else if (cell_q[40] || !fit_q || addr_d >= 48'(StoreDepth)) begin
      err_d = ERR_OUTSIDE;
    end else begin
      err_d = ERR_OK;
    end
  end

  // floating add
  logic [DataW-1:0] ram_rdata;
  logic [DataW-1:0] fa, fb, big, sml, spec_val, res_q, rnd;
  logic             a_nan, b_nan, a_inf, b_inf, special, swap;
  logic             fsign_q, fsub_q, special_q;
  logic [11:0]      fe_q, fdiff_q, e_big, e_sml;
  logic [55:0]      fma_q, fmb_q, fs_q, shifted, smask;
  logic [56:0]      sum;
  logic             norm_done, rup;
  logic [10:0]      expf;

  assign fa = ram_rdata;
  assign fb = value_q;
  assign a_nan = (&fa[62:52]) && (|fa[51:0]);
  assign b_nan = (&fb[62:52]) && (|fb[51:0]);
  assign a_inf = (&fa[62:52]) && !(|fa[51:0]);
  assign b_inf = (&fb[62:52]) && !(|fb[51:0]);
  assign special = (&fa[62:52]) || (&fb[62:52]);
  assign swap = fb[62:0] > fa[62:0];
  assign big  = swap ? fb : fa;
  assign sml  = swap ? fa : fb;
  assign e_big = (big[62:52] == 11'd0) ? 12'd1 : {1'b0, big[62:52]};
  assign e_sml = (sml[62:52] == 11'd0) ? 12'd1 : {1'b0, sml[62:52]};

  always_comb begin
    // first operand NaN wins, quieted
    if (a_nan) begin
      spec_val = fa | (64'd1 << 51);
    end else if (b_nan) begin
      spec_val = fb | (64'd1 << 51);
    end else if (a_inf && b_inf && (fa[63] ^ fb[63])) begin
      spec_val = 64'hFFF8_0000_0000_0000;
    end else if (a_inf) begin
      spec_val = fa;
    end else begin
      spec_val = fb;
    end
  end

  assign smask   = ~(56'hFF_FFFF_FFFF_FFFF << fdiff_q[5:0]);
  assign shifted = (fdiff_q >= 12'd56) ? {55'b0, |fmb_q}
                 : ((fmb_q >> fdiff_q[5:0]) | {55'b0, |(fmb_q & smask)});
  assign sum = fsub_q ? ({1'b0, fma_q} - {1'b0, fmb_q}) : ({1'b0, fma_q} + {1'b0, fmb_q});
  assign norm_done = fs_q[55] || (fe_q <= 12'd1) || (fs_q == 56'd0);
  assign expf = fs_q[55] ? fe_q[10:0] : 11'd0;
  assign rup  = fs_q[2] & (fs_q[1] | fs_q[0] | fs_q[3]);

  always_comb begin
    if (fs_q == 56'd0) begin
      rnd = {fsign_q & ~fsub_q, 63'b0};
    end else if (fe_q >= 12'h7FF) begin
      rnd = {fsign_q, 11'h7FF, 52'b0};
    end else begin
      rnd = {fsign_q, expf, fs_q[54:3]} + 64'(rup);
    end
  end

  // clearing pass
  logic [AddrW-1:0] clr_cnt_q;
  logic             clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
      phase_q    <= 2'd0;
      cnt_q      <= 4'd0;
    end else begin
      if (op_i == OP_CLEAR && !clr_done_q) begin
        if (clr_cnt_q == AddrW'(StoreDepth - 1)) clr_done_q <= 1'b1;
        else clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (op_i == OP_LOAD) begin
        phase_q <= 2'd0;
      end else if (op_i == OP_DIV_LOAD) begin
        cnt_q <= 4'd0;
      end else if (op_i == OP_DIV_STEP) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) phase_q <= phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        row_q   <= in_data_i.row_index;
        col_q   <= in_data_i.col_index;
        brow_q  <= in_data_i.block_row;
        bcol_q  <= in_data_i.block_col;
        value_q <= in_data_i.value;
        acc_q   <= in_data_i.accumulate;
      end
      OP_SETUP: begin
        gx_q    <= {1'b0, cells_x_q} + 12'd2;
        plane_q <= ({13'b0, cells_x_q} + 24'd2) * ({13'b0, cells_y_q} + 24'd2);
        nxny_q  <= 22'(cells_x_q) * 22'(cells_y_q);
      end
      OP_DIV_LOAD: begin
        rem_q <= '0;
        quo_q <= '0;
        case (phase_q)
          2'd0: begin dvd_q <= row_q;  divisor_q <= plane_q;       end
          2'd1: begin dvd_q <= prem_q; divisor_q <= {12'b0, gx_q}; end
          2'd2: begin dvd_q <= col_q;  divisor_q <= plane_q;       end
          default: begin dvd_q <= prem_q; divisor_q <= {12'b0, gx_q}; end
        endcase
      end
      OP_DIV_STEP: begin
        dvd_q <= {dvd_q[14:0], 1'b0};
        rem_q <= rem_n;
        quo_q <= quo_n;
        if (cnt_q == 4'd15) begin
          case (phase_q)
            2'd0: begin zq_r_q <= quo_n; prem_q <= rem_n;        end
            2'd1: begin yq_r_q <= quo_n; xm_r_q <= rem_n[11:0];  end
            2'd2: begin zq_c_q <= quo_n; prem_q <= rem_n;        end
            default: begin yq_c_q <= quo_n; xm_c_q <= rem_n[11:0]; end
          endcase
        end
      end
      OP_POINT: begin
        pt_q     <= ptres[2:0];
        nb_err_q <= ~ptres[3];
        t1_q     <= t1_d;
        t2_q     <= t2_d;
        xr_q     <= xr;
        fit_q    <= ({1'b0, brow_q} < dsz) && ({1'b0, bcol_q} < dsz);
      end
      OP_SUM: cell_q <= t1_q + t2_q + xr_q;
      OP_AMUL: begin
        prod_q <= 48'(cell_q[39:0]) * 48'(kmul);
        ofs_q  <= 8'(pt_q) * 8'(dd) + 8'(brow_q) * 8'(dsz) + 8'(bcol_q);
      end
      OP_ACHK: begin
        addr_q <= addr_d;
        err_q  <= err_d;
      end
      OP_INSERT: res_q <= value_q;
      OP_UNPACK: begin
        special_q <= special;
        res_q     <= spec_val;
        fsign_q   <= big[63];
        fsub_q    <= fa[63] ^ fb[63];
        fe_q      <= e_big;
        fdiff_q   <= e_big - e_sml;
        fma_q     <= {|big[62:52], big[51:0], 3'b0};
        fmb_q     <= {|sml[62:52], sml[51:0], 3'b0};
      end
      OP_ALIGN: fmb_q <= shifted;
      OP_ADD: begin
        if (sum[56]) begin
          fs_q <= {sum[56:2], sum[1] | sum[0]};
          fe_q <= fe_q + 12'd1;
        end else begin
          fs_q <= sum[55:0];
        end
      end
      OP_NORM: begin
        if (!norm_done) begin
          fs_q <= {fs_q[54:0], 1'b0};
          fe_q <= fe_q - 12'd1;
        end
      end
      OP_ROUND: res_q <= rnd;
      default: ;
    endcase
  end

  // store
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;

  always_comb begin
    if (op_i == OP_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q[AddrW-1:0];
      ram_wdata = res_q;
    end else begin
      ram_we    = (op_i == OP_CLEAR) && !clr_done_q;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end
  end

  smei_ram #(
    .WIDTH (DataW),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (op_i == OP_READ),
    .raddr_i (addr_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD_OUT) begin
      out_q.error_code    <= err_q;
      out_q.entry_address <= (err_q == ERR_OK) ? addr_q[OutAW-1:0] : '0;
      out_q.new_value     <= (err_q == ERR_OK) ? res_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.clear_done     = clr_done_q;
  assign status_o.div_step_last  = (cnt_q == 4'd15);
  assign status_o.div_phase_last = (phase_q == 2'd3);
  assign status_o.err            = (err_q != ERR_OK);
  assign status_o.accumulate     = acc_q;
  assign status_o.fp_special     = special_q;
  assign status_o.norm_done      = norm_done;
  assign status_o.out_free       = !out_valid_q || !out_stall_i;

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_WRITE |-> err_q == ERR_OK && clr_done_q)
    else $error("store write on a refused item");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error_code != ERR_OK) |->
      (out_q.new_value == '0 && out_q.entry_address == '0))
    else $error("error result carries payload");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_done_q |=> clr_done_q)
    else $error("clearing pass restarted");

  a_norm_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_NORM |-> fe_q != 12'd0)
    else $error("exponent underflow in normalize");

endmodule

>>> design/smei_ctrl.sv
`timescale 1ns / 1ps

module smei_ctrl
  import smei_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        op_o = OP_CLEAR;
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        op_o    = OP_SETUP;
        state_d = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        op_o    = OP_DIV_LOAD;
        state_d = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        op_o = OP_DIV_STEP;
        if (status_i.div_step_last) begin
          state_d = status_i.div_phase_last ? ST_POINT : ST_DIV_LOAD;
        end
      end
      ST_POINT: begin
        op_o    = OP_POINT;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        op_o    = OP_SUM;
        state_d = ST_AMUL;
      end
      ST_AMUL: begin
        op_o    = OP_AMUL;
        state_d = ST_ACHK;
      end
      ST_ACHK: begin
        op_o    = OP_ACHK;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.err) begin
          state_d = ST_OUT;
        end else if (status_i.accumulate) begin
          op_o    = OP_READ;
          state_d = ST_UNPACK;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        op_o    = OP_INSERT;
        state_d = ST_WRITE;
      end
      ST_UNPACK: begin
        op_o    = OP_UNPACK;
        state_d = ST_ALIGN;
      end
      ST_ALIGN: begin
        // NaN or infinity operands already have their result
        if (status_i.fp_special) begin
          state_d = ST_WRITE;
        end else begin
          op_o    = OP_ALIGN;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        op_o    = OP_ADD;
        state_d = ST_NORM;
      end
      ST_NORM: begin
        if (status_i.norm_done) begin
          op_o    = OP_ROUND;
          state_d = ST_WRITE;
        end else begin
          op_o = OP_NORM;
        end
      end
      ST_WRITE: begin
        op_o    = OP_WRITE;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          op_o    = OP_LOAD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> design/stencil_matrix_entry_insert.sv
`timescale 1ns / 1ps
// Seven-point stencil matrix entry store with insert / accumulate.
// Input channel in_valid_i / in_stall_o carries one entry item (ghosted row and
// column cell indices, block position, double value, accumulate flag). Output
// channel out_valid_o / out_stall_i returns one result item per entry: store
// address, the double now held there, and an error code.
// Config port cfg_valid_i / cfg_ready_o writes cells_x, cells_y, dof_count by
// index; ready is always high, write only while the block is idle.
// The four index divisions run on one shared radix-2 divider, 16 steps each;
// an accumulate also reads the entry and runs a normalize loop of the double
// adder that shifts one bit per cycle.
// One item is worked at a time; the next is taken the cycle after the result
// enters the output register, even if that result is still waiting.
// Reset: after rst_ni releases, the store is cleared one entry per cycle,
// all MAX_CELLS*7*MAX_DOF*MAX_DOF entries (28672 by default), and in_stall_o
// stays high until then. A stalled result holds in the output register; the
// block finishes the item in hand and then waits.

module stencil_matrix_entry_insert
  import smei_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MaxCellsDef,
  parameter int unsigned MAX_DOF   = MaxDofDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  dp_op_e     op;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  smei_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  smei_dp #(
    .MAX_CELLS (MAX_CELLS),
    .MAX_DOF   (MAX_DOF)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> dv/stencil_matrix_entry_insert_tb.sv
`timescale 1ns / 1ps

module stencil_matrix_entry_insert_tb;
  import smei_pkg::*;

  localparam int StoreDepth = MaxCellsDef * StencilPoints * MaxDofDef * MaxDofDef;
  localparam int QuietLimit = 60000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } entry_vec_t;

  typedef struct {
    bit        typed;
    out_item_t res;
  } typed_res_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_item_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_item_t       out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = CFG_CELLS_X;
  logic [CfgW-1:0] cfg_data_i = '0;

  // predictor state
  logic [DataW-1:0] entry_mem [int];
  logic [CfgW-1:0]  cells_x_q = 1, cells_y_q = 1;
  logic [1:0]       dof_q = 1;

  out_item_t  result_q [$];
  typed_res_t typed_q [$];
  entry_vec_t dir_tbl [$];
  int err_cnt = 0;
  int quiet_cnt = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  stencil_matrix_entry_insert u_dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic bit is_nan(logic [DataW-1:0] v);
    return (&v[62:52]) && (|v[51:0]);
  endfunction

  function automatic void split_cell(input longint idx, input longint gx, input longint plane,
                                     output longint x, output longint y, output longint z);
    longint r;
    r = idx % plane;
    z = idx / plane - 1;
    y = r / gx - 1;
    x = r % gx - 1;
  endfunction

  function automatic int point_of(longint dx, longint dy, longint dz);
    if (dy == 0 && dz == 0) begin
      if (dx == 0) return PT_CENTER;
      if (dx == -1) return PT_XM;
      if (dx == 1) return PT_XP;
    end
    if (dx == 0 && dz == 0) begin
      if (dy == -1) return PT_YM;
      if (dy == 1) return PT_YP;
    end
    if (dx == 0 && dy == 0) begin
      if (dz == -1) return PT_ZM;
      if (dz == 1) return PT_ZP;
    end
    return -1;
  endfunction

  function automatic out_item_t insert_entry(in_item_t it);
    out_item_t o;
    longint nx, ny, gx, plane, d, xr, yr, zr, xc, yc, zc, cell_no, addr, m, l;
    int pt;
    logic [DataW-1:0] old;
    o = '0;
    nx = cells_x_q;
    ny = cells_y_q;
    gx = nx + 2;
    plane = gx * (ny + 2);
    d = dof_q;
    if (d < 1) d = 1;
    if (d > MaxDofDef) d = MaxDofDef;
    m = it.block_row;
    l = it.block_col;
    split_cell(it.row_index, gx, plane, xr, yr, zr);
    split_cell(it.col_index, gx, plane, xc, yc, zc);
    pt = point_of(xc - xr, yc - yr, zc - zr);
    if (pt < 0) begin
      o.error_code = ERR_NOT_NEIGHBOR;
      return o;
    end
    cell_no = zr * nx * ny + yr * nx + xr;
    if (cell_no < 0 || m >= d || l >= d) begin
      o.error_code = ERR_OUTSIDE;
      return o;
    end
    addr = cell_no * StencilPoints * d * d + pt * d * d + m * d + l;
    if (addr >= StoreDepth) begin
      o.error_code = ERR_OUTSIDE;
      return o;
    end
    old = entry_mem.exists(int'(addr)) ? entry_mem[int'(addr)] : '0;
    if (!it.accumulate) entry_mem[int'(addr)] = it.value;
    else entry_mem[int'(addr)] = $realtobits($bitstoreal(old) + $bitstoreal(it.value));
    o.entry_address = addr[OutAW-1:0];
    o.new_value = entry_mem[int'(addr)];
    o.error_code = ERR_OK;
    return o;
  endfunction

  // accepted items feed the predictor
  always @(posedge clk_i) begin
    typed_res_t t;
    out_item_t  p;
    if (in_valid_i && !in_stall_o) begin
      if (typed_q.size() != 0) begin
        t = typed_q.pop_front();
      end else begin
        t.typed = 1'b0;
        t.res = '0;
      end
      p = insert_entry(in_data_i);
      result_q.push_back(t.typed ? t.res : p);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CELLS_X: cells_x_q <= cfg_data_i;
        CFG_CELLS_Y: cells_y_q <= cfg_data_i;
        CFG_DOF:     dof_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", out_data_o));
      end else begin
        e = result_q.pop_front();
        if (out_data_o.error_code !== e.error_code)
          report($sformatf("error_code %0d, expected %0d", out_data_o.error_code, e.error_code));
        if (out_data_o.entry_address !== e.entry_address)
          report($sformatf("entry_address %0d, expected %0d",
                           out_data_o.entry_address, e.entry_address));
        if (out_data_o.new_value !== e.new_value &&
            !(is_nan(out_data_o.new_value) && is_nan(e.new_value)))
          report($sformatf("new_value %h, expected %h", out_data_o.new_value, e.new_value));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_entry(input in_item_t it, input bit typed, input out_item_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    typed_q.push_back('{typed: typed, res: res});
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do begin
      @(negedge clk_i);
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CfgW-1:0];
    do begin
      @(negedge clk_i);
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_entry(int row, int col, bit m, bit l,
                                        logic [DataW-1:0] v, bit acc);
    in_item_t it;
    it.row_index = row[IdxW-1:0];
    it.col_index = col[IdxW-1:0];
    it.block_row = m;
    it.block_col = l;
    it.value = v;
    it.accumulate = acc;
    return it;
  endfunction

  // mostly a real row cell with a stencil neighbor as column
  function automatic in_item_t rand_entry();
    in_item_t it;
    int gx, plane, row;
    int offs [7];
    logic [DataW-1:0] v;
    gx = cells_x_q + 2;
    plane = gx * (cells_y_q + 2);
    offs = '{0, -1, 1, -gx, gx, -plane, plane};
    v = ($urandom_range(1)) ? {$urandom, $urandom}
                            : $realtobits(real'($urandom_range(2000)) / 8.0 - 125.0);
    if ($urandom_range(99) < 80) begin
      row = $urandom_range(65535 / plane) * plane + $urandom_range(plane - 1);
      if (plane > 65535) row = $urandom_range(65535);
      it = mk_entry(row, row + offs[$urandom_range(6)], $urandom_range(1), $urandom_range(1),
                    v, $urandom_range(1));
    end else begin
      it = mk_entry($urandom_range(65535), $urandom_range(65535), $urandom_range(1),
                    $urandom_range(1), {$urandom, $urandom}, $urandom_range(1));
    end
    return it;
  endfunction

  initial begin
    int unsigned cfg_tbl [7][3];
    int pct_tbl [4][2];
    out_item_t r;
    cfg_tbl = '{'{1, 1, 1}, '{4, 3, 2}, '{0, 0, 0}, '{1024, 1024, 3},
                '{2047, 5, 2}, '{7, 2047, 1}, '{6, 5, 2}};
    pct_tbl = '{'{0, 0}, '{60, 0}, '{0, 60}, '{30, 30}};

    // default sizes: ghosted row 3, plane 9; index 13 is interior cell 0
    r = '0;
    r.new_value = 64'h3FF0_0000_0000_0000;
    dir_tbl.push_back('{mk_entry(13, 13, 0, 0, 64'h3FF0_0000_0000_0000, 0), 1, r});
    r.new_value = 64'h4000_0000_0000_0000;
    dir_tbl.push_back('{mk_entry(13, 13, 0, 0, 64'h3FF0_0000_0000_0000, 1), 1, r});
    r = '0;
    r.error_code = ERR_NOT_NEIGHBOR;
    dir_tbl.push_back('{mk_entry(13, 0, 0, 0, 64'h1, 0), 1, r});
    r.error_code = ERR_OUTSIDE;
    dir_tbl.push_back('{mk_entry(13, 13, 1, 0, 64'h1, 0), 1, r});
    dir_tbl.push_back('{mk_entry(13, 13, 0, 1, 64'h1, 1), 1, r});
    dir_tbl.push_back('{mk_entry(0, 0, 0, 0, 64'h1, 0), 1, r});
    dir_tbl.push_back('{mk_entry(65535, 65535, 1, 1, '1, 1), 1, r});
    dir_tbl.push_back('{mk_entry(13, 12, 0, 0, '1, 0), 0, r});
    dir_tbl.push_back('{mk_entry(13, 14, 0, 0, '0, 0), 0, r});
    dir_tbl.push_back('{mk_entry(13, 10, 0, 0, 64'hC000_0000_0000_0000, 0), 0, r});
    dir_tbl.push_back('{mk_entry(13, 16, 0, 0, 64'h7FF0_0000_0000_0000, 0), 0, r});
    dir_tbl.push_back('{mk_entry(13, 4, 0, 0, 64'h0000_0000_0000_0001, 0), 0, r});
    dir_tbl.push_back('{mk_entry(13, 22, 0, 0, 64'h8000_0000_0000_0000, 1), 0, r});
    dir_tbl.push_back('{mk_entry(13, 12, 0, 0, 64'h3FF0_0000_0000_0000, 1), 0, r});
    dir_tbl.push_back('{mk_entry(4, 13, 0, 0, 64'h4010_0000_0000_0000, 0), 0, r});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) send_entry(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].res);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_CELLS_X, cfg_tbl[ph][0]);
      write_reg(CFG_CELLS_Y, cfg_tbl[ph][1]);
      write_reg(CFG_DOF, cfg_tbl[ph][2]);
      @(posedge clk_i);
      for (int n = 0; n < 190; n++) begin
        send_idle_pct = pct_tbl[(ph + n / 48) % 4][0];
        recv_stall_pct = pct_tbl[(ph + n / 48) % 4][1];
        // hold off until the block has emptied out
        if (n == 100) drain();
        send_entry(rand_entry(), 0, '0);
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (result_q.size() != 0) report($sformatf("%0d results never came", result_q.size()));
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
